/* rtl/byte_budget_lru_cache_defines.svh */
// ----------------------------------------------------------------------------
// Byte budget LRU cache assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_DEFINES_SVH

// Same-cycle implication.
`define BBLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bblc_pkg.sv */
// ----------------------------------------------------------------------------
// Byte budget LRU cache package
// Key type, stored entry type, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package bblc_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam logic [40:0] BUDGET_RESET = 41'd4294967296;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [7:0]  tex_format;
    logic        has_palette;
    logic        mipmapped;
    logic [10:0] tex_height;
    logic [10:0] tex_width;
    logic [63:0] palette_hash;
    logic [63:0] texture_hash;
  } key_t;

  typedef struct packed {
    logic [31:0] entry_bytes;
    key_t        key;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_CHECK,
    ST_EVICT,
    ST_DONE
  } state_t;

  // Subtract a byte count from the running total, floor at zero.
  function automatic logic [41:0] sub_sat(input logic [41:0] t, input logic [31:0] b);
    logic [41:0] bx;
    bx = {10'd0, b};
    return (t > bx) ? (t - bx) : 42'd0;
  endfunction

endpackage

/* rtl/byte_budget_lru_cache.sv */
// ----------------------------------------------------------------------------
// Byte budget LRU cache directory
// Keyed texture directory with per-entry byte sizes, recency ranks and
// eviction of least recent entries while the byte total exceeds a budget.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. All directory work is done by a
// single walk engine that visits one slot at a time through the
// entry memory's one read port (address, then registered data and write
// back). A lookup takes a search walk, plus an update walk on a hit. An
// insert takes a search walk and an update walk, plus one more walk for
// every entry evicted by the budget, plus the decide and check states. A
// clear sweeps the rank memory. After reset the same sweep runs before
// the first item is taken; budget writes are taken at any time. Ranks of
// valid slots are always a permutation of 0..count-1, so the least recent
// slot is the one whose rank is count-1.
module byte_budget_lru_cache #(
  parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // budget_bytes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [40:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // texture_hash, palette_hash, tex_width, tex_height, mipmapped,
  // has_palette, tex_format, entry_bytes
  input  logic [191:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot, evicted_count, total_bytes, zero pad
  output logic [55:0]  m_tdata,
  // hit
  output logic         m_tuser
);
  import bblc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // Directory storage: key and bytes per slot, {valid, rank} per slot.
  entry_t          key_mem  [ENTRIES];
  logic [IW:0]     meta_mem [ENTRIES];
  entry_t          key_rd;
  logic [IW:0]     meta_rd;

  state_t          state, state_next;
  logic [IW-1:0]   idx, idx_next;
  logic            phase, phase_next;
  func_t           func_q, func_q_next;
  key_t            key_q, key_q_next;
  logic [31:0]     bytes_q, bytes_q_next;
  logic            found, found_next;
  logic [IW-1:0]   s_idx, s_idx_next;
  logic [IW-1:0]   old_rank, old_rank_next;
  logic [31:0]     old_bytes, old_bytes_next;
  logic            free_found, free_found_next;
  logic [IW-1:0]   free_idx, free_idx_next;
  logic [IW-1:0]   victim_idx, victim_idx_next;
  logic [31:0]     victim_bytes, victim_bytes_next;
  logic            bump_all, bump_all_next;
  logic            hit_q, hit_q_next;
  logic [IW:0]     vcount, vcount_next;
  logic [41:0]     total, total_next;
  logic [40:0]     budget;
  logic [6:0]      evicted, evicted_next;

  logic            meta_we, key_we;
  logic [IW:0]     meta_wdata;
  logic [IW:0]     vcount_m1;
  logic            rd_valid;
  logic [IW-1:0]   rd_rank;
  logic            key_eq;
  logic            over_budget;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_DONE);
  assign m_tuser   = hit_q;
  assign m_tdata   = {2'b00, total[40:0], evicted, 6'(s_idx)};

  assign vcount_m1   = vcount - (IW+1)'(1);
  assign rd_valid    = meta_rd[IW];
  assign rd_rank     = meta_rd[IW-1:0];
  assign key_eq      = (key_rd.key == key_q);
  assign over_budget = (total > {1'b0, budget});

  // Memory ports: read at the walk address every cycle, write back on demand.
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[idx];
    meta_rd <= meta_mem[idx];
    if (meta_we) begin
      meta_mem[idx] <= meta_wdata;
    end
    if (key_we) begin
      key_mem[idx] <= '{entry_bytes: bytes_q, key: key_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (cfg_valid) begin
      budget <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      idx    <= '0;
      phase  <= 1'b0;
      func_q <= FN_LOOKUP;
      vcount <= '0;
      total  <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      phase  <= phase_next;
      func_q <= func_q_next;
      vcount <= vcount_next;
      total  <= total_next;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    key_q        <= key_q_next;
    bytes_q      <= bytes_q_next;
    found        <= found_next;
    s_idx        <= s_idx_next;
    old_rank     <= old_rank_next;
    old_bytes    <= old_bytes_next;
    free_found   <= free_found_next;
    free_idx     <= free_idx_next;
    victim_idx   <= victim_idx_next;
    victim_bytes <= victim_bytes_next;
    bump_all     <= bump_all_next;
    hit_q        <= hit_q_next;
    evicted      <= evicted_next;
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    phase_next        = phase;
    func_q_next       = func_q;
    key_q_next        = key_q;
    bytes_q_next      = bytes_q;
    found_next        = found;
    s_idx_next        = s_idx;
    old_rank_next     = old_rank;
    old_bytes_next    = old_bytes;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    victim_idx_next   = victim_idx;
    victim_bytes_next = victim_bytes;
    bump_all_next     = bump_all;
    hit_q_next        = hit_q;
    vcount_next       = vcount;
    total_next        = total;
    evicted_next      = evicted;
    meta_we           = 1'b0;
    key_we            = 1'b0;
    meta_wdata        = '0;

    case (state)
      // Sweep the rank memory to empty; after reset or on a clear.
      ST_INIT: begin
        meta_we  = 1'b1;
        idx_next = idx + IW'(1);
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = (func_q == FN_CLEAR) ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_tvalid) begin
          func_q_next = func_t'(s_tuser);
          key_q_next  = key_t'(s_tdata[159:0]);
          bytes_q_next = s_tdata[191:160];
          found_next      = 1'b0;
          free_found_next = 1'b0;
          hit_q_next      = 1'b0;
          s_idx_next      = '0;
          evicted_next    = '0;
          idx_next        = '0;
          phase_next      = 1'b0;
          case (func_t'(s_tuser))
            FN_LOOKUP, FN_INSERT: state_next = ST_SEARCH;
            FN_CLEAR: begin
              total_next  = '0;
              vcount_next = '0;
              state_next  = ST_INIT;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      // Find the key, the lowest free slot and the least recent slot.
      ST_SEARCH: begin
        phase_next = ~phase;
        if (phase) begin
          if (rd_valid && key_eq && !found) begin
            found_next     = 1'b1;
            s_idx_next     = idx;
            old_rank_next  = rd_rank;
            old_bytes_next = key_rd.entry_bytes;
          end
          if (!rd_valid && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
          if (rd_valid && (rd_rank == vcount_m1[IW-1:0])) begin
            victim_idx_next   = idx;
            victim_bytes_next = key_rd.entry_bytes;
          end
          idx_next = idx + IW'(1);
          if (idx == LAST) begin
            idx_next   = '0;
            state_next = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        bump_all_next = 1'b0;
        state_next    = ST_UPDATE;
        if (func_q == FN_LOOKUP) begin
          hit_q_next = found;
          if (!found) begin
            state_next = ST_DONE;
          end
        end else if (found) begin
          hit_q_next = 1'b1;
          total_next = sub_sat(total, old_bytes);
        end else if (free_found) begin
          s_idx_next    = free_idx;
          bump_all_next = 1'b1;
          vcount_next   = vcount + (IW+1)'(1);
        end else begin
          // Full table: the least recent slot makes room for the new key.
          s_idx_next    = victim_idx;
          bump_all_next = 1'b1;
          evicted_next  = 7'd1;
          total_next    = sub_sat(total, victim_bytes);
        end
      end

      // Age the slots more recent than the chosen one (all others for a new key)
      ST_UPDATE: begin
        phase_next = ~phase;
        if (phase) begin
          if (idx == s_idx) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, {IW{1'b0}}};
            key_we     = (func_q == FN_INSERT);
          end else if (rd_valid && (bump_all || (rd_rank < old_rank))) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, rd_rank + IW'(1)};
          end
          idx_next = idx + IW'(1);
          if (idx == LAST) begin
            idx_next = '0;
            if (func_q == FN_INSERT) begin
              total_next = total + {10'd0, bytes_q};
              state_next = ST_CHECK;
            end else begin
              state_next = ST_DONE;
            end
          end
        end
      end

      ST_CHECK: begin
        if (over_budget && (vcount != '0)) begin
          state_next = ST_EVICT;
          phase_next = 1'b0;
          idx_next   = '0;
        end else begin
          state_next = ST_DONE;
        end
      end

      // Drop the slot holding the highest rank.
      ST_EVICT: begin
        phase_next = ~phase;
        if (phase) begin
          if (rd_valid && (rd_rank == vcount_m1[IW-1:0])) begin
            meta_we    = 1'b1;
            total_next = sub_sat(total, key_rd.entry_bytes);
          end
          idx_next = idx + IW'(1);
          if (idx == LAST) begin
            idx_next     = '0;
            vcount_next  = vcount_m1;
            evicted_next = (evicted == 7'd127) ? evicted : evicted + 7'd1;
            state_next   = ST_CHECK;
          end
        end
      end

      ST_DONE: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

`include "byte_budget_lru_cache_defines.svh"

  `BBLC_ASSERT_NOW(a_count_bound, 1'b1, vcount <= (IW+1)'(ENTRIES), "valid count out of range")
  `BBLC_ASSERT_NOW(a_one_side, s_tready, !m_tvalid, "input and output open together")
  `BBLC_ASSERT_NEXT(a_check_done, state == ST_CHECK && !over_budget, state == ST_DONE, "stuck")
  `BBLC_ASSERT_NOW(a_evict_insert, m_tvalid && func_q != FN_INSERT, evicted == '0, "stray eviction")

endmodule
